// ===== hw/rtl/fenw_pkg.sv =====
// Shared widths, defaults and controller/datapath command and status types for the Fenwick range block.
package fenw_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned TREE_SIZE_DEF = 1024;
  localparam int unsigned S_TDATA_W     = 56;  // lo, hi, add_value packed, padded to bytes
  localparam int unsigned M_TDATA_W     = 32;

  typedef enum logic [1:0] {
    MUL_NONE    = 2'd0,
    MUL_LO_TERM = 2'd1,
    MUL_HI_TERM = 2'd2,
    MUL_PREFIX  = 2'd3
  } fenw_mul_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic          clear;        // write zero at the sweep counter, advance it
    logic          latch;        // capture the input beat
    fenw_mul_sel_e mul_sel;      // operand pair for the shared multiplier
    logic          ld_lo_chain;  // start the update chain at lo
    logic          ld_hi_chain;  // start the update chain at hi + 1
    logic          upd_step;     // walk up one node, read-modify-write
    logic          ld_pre;       // start a prefix walk
    logic          qry_step;     // walk down one node, accumulate
    logic          fin;          // fold the prefix into the result
    logic          out_set;      // load the output register
    logic          phase_lo;     // prefix walk at lo - 1 (else at hi)
  } fenw_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;
    logic up_done;
    logic dn_done;
    logic out_full;
  } fenw_sts_t;

endpackage

// ===== hw/rtl/fenw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fenw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fenw_datapath.sv =====
// Datapath: tree memory, index walker, shared multiplier, accumulators and output register.
module fenw_datapath #(
  parameter int unsigned TREE_SIZE = fenw_pkg::TREE_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fenw_pkg::S_TDATA_W-1:0] in_data_i,
  input  fenw_pkg::fenw_ctl_t            ctl_i,
  output fenw_pkg::fenw_sts_t            sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [fenw_pkg::M_TDATA_W-1:0] out_data_o
);
  import fenw_pkg::*;

  localparam int unsigned ADDR_W = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
  localparam int unsigned POS_W  = (ADDR_W > IDX_W) ? ADDR_W + 1 : IDX_W + 1;
  localparam int unsigned MUL_W  = DATA_W + IDX_W;
  localparam int unsigned RAM_W  = 2 * DATA_W;
  localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(TREE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TREE_SIZE - 1);

  logic [IDX_W-1:0]  lo_q, hi_q, idx_q;
  logic [DATA_W-1:0] val_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] dslope_q, doff_q;
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] acc_s1_q, acc_s2_q;
  logic [DATA_W-1:0] hi_part_q, out_data_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              upd_pend_q, qry_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;

  logic [POS_W-1:0]  pos_low;
  logic              pos_in;
  logic              up_issue, dn_issue;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [DATA_W-1:0] neg_val;
  logic [IDX_W-1:0]  lo_m1, lo_dec;
  logic [DATA_W-1:0] mul_a;
  logic [IDX_W-1:0]  mul_b;
  logic [MUL_W-1:0]  mul_full;
  logic [DATA_W-1:0] term;

  assign pos_low   = pos_q & (~pos_q + POS_W'(1));
  assign pos_in    = (pos_q != '0) && (pos_q < POS_LIMIT);
  assign up_issue  = ctl_i.upd_step && pos_in;
  assign dn_issue  = ctl_i.qry_step && pos_in;
  assign neg_val   = '0 - val_q;
  assign lo_dec    = lo_q - IDX_W'(1);
  assign lo_m1     = (lo_q == '0) ? '0 : lo_dec;
  assign term      = prod_q - acc_s2_q;

  // Entry layout: offset in the upper half, slope in the lower half
  assign ram_re    = up_issue || dn_issue;
  assign ram_raddr = pos_q[ADDR_W-1:0];
  assign ram_we    = ctl_i.clear || upd_pend_q;
  assign ram_waddr = ctl_i.clear ? clr_cnt_q : wr_addr_q;
  assign ram_wdata = ctl_i.clear ? '0 :
                     {ram_rdata[RAM_W-1:DATA_W] + doff_q, ram_rdata[DATA_W-1:0] + dslope_q};

  fenw_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TREE_SIZE)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mul_a = val_q;
    mul_b = lo_dec;
    case (ctl_i.mul_sel)
      MUL_LO_TERM: begin
        mul_a = val_q;
        mul_b = lo_dec;
      end
      MUL_HI_TERM: begin
        mul_a = neg_val;
        mul_b = hi_q;
      end
      MUL_PREFIX: begin
        mul_a = acc_s1_q;
        mul_b = idx_q;
      end
      default: begin
        mul_a = val_q;
        mul_b = lo_dec;
      end
    endcase
  end

  assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    pos_d = pos_q;
    if (ctl_i.ld_lo_chain) begin
      pos_d = POS_W'(lo_q);
    end else if (ctl_i.ld_hi_chain) begin
      pos_d = POS_W'(hi_q) + POS_W'(1);
    end else if (ctl_i.ld_pre) begin
      pos_d = ctl_i.phase_lo ? POS_W'(lo_m1) : POS_W'(hi_q);
    end else if (ctl_i.upd_step && pos_in) begin
      pos_d = pos_q + pos_low;
    end else if (ctl_i.qry_step && (pos_q != '0)) begin
      pos_d = pos_q - pos_low;
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
      upd_pend_q  <= 1'b0;
      qry_pend_q  <= 1'b0;
    end else begin
      upd_pend_q <= up_issue;
      qry_pend_q <= dn_issue;
      if (ctl_i.clear) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (ctl_i.out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (ctl_i.latch) begin
      lo_q  <= in_data_i[IDX_W-1:0];
      hi_q  <= in_data_i[2*IDX_W-1:IDX_W];
      val_q <= in_data_i[2*IDX_W+DATA_W-1:2*IDX_W];
    end
    if (up_issue) begin
      wr_addr_q <= ram_raddr;
    end
    if (ctl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_full[DATA_W-1:0];
    end
    if (ctl_i.ld_lo_chain) begin
      dslope_q <= val_q;
      doff_q   <= prod_q;
    end else if (ctl_i.ld_hi_chain) begin
      dslope_q <= neg_val;
      doff_q   <= prod_q;
    end
    if (ctl_i.ld_pre) begin
      idx_q    <= ctl_i.phase_lo ? lo_m1 : hi_q;
      acc_s1_q <= '0;
      acc_s2_q <= '0;
    end else if (qry_pend_q) begin
      acc_s1_q <= acc_s1_q + ram_rdata[DATA_W-1:0];
      acc_s2_q <= acc_s2_q + ram_rdata[RAM_W-1:DATA_W];
    end
    if (ctl_i.fin && !ctl_i.phase_lo) begin
      hi_part_q <= term;
    end
    if (ctl_i.out_set) begin
      out_data_q <= hi_part_q - term;
    end
  end

  assign sts_o.clear_done = (clr_cnt_q == LAST_ADDR);
  assign sts_o.up_done    = !pos_in;
  assign sts_o.dn_done    = (pos_q == '0);
  assign sts_o.out_full   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The write-back of one node never meets a read of the same node
  a_no_rmw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_pend_q && ram_re) |-> (ram_raddr != wr_addr_q))
    else $error("read issued at the node being written back");

  // A new result is loaded only when the output register is free or draining
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_set |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // The clearing sweep never overlaps a tree walk
  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |-> (!ram_re && !upd_pend_q))
    else $error("tree access during the clearing sweep");

endmodule

// ===== hw/rtl/fenw_ctrl.sv =====
// Controller: sequences clearing, range updates and range sums over the datapath.
module fenw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  input  fenw_pkg::fenw_sts_t sts_i,
  output fenw_pkg::fenw_ctl_t ctl_o
);
  import fenw_pkg::*;

  typedef enum logic [10:0] {
    ST_CLEAR     = 11'b000_0000_0001,
    ST_IDLE      = 11'b000_0000_0010,
    ST_A_MUL     = 11'b000_0000_0100,
    ST_A_LO      = 11'b000_0000_1000,
    ST_A_LO_WALK = 11'b000_0001_0000,
    ST_A_HI      = 11'b000_0010_0000,
    ST_A_HI_WALK = 11'b000_0100_0000,
    ST_S_LD      = 11'b000_1000_0000,
    ST_S_WALK    = 11'b001_0000_0000,
    ST_S_MUL     = 11'b010_0000_0000,
    ST_S_FIN     = 11'b100_0000_0000
  } fenw_state_e;

  fenw_state_e state_q, state_d;
  logic        phase_lo_q, phase_lo_d;

  always_comb begin
    state_d      = state_q;
    phase_lo_d   = phase_lo_q;
    in_ready_o   = 1'b0;
    ctl_o        = '0;
    ctl_o.mul_sel  = MUL_NONE;
    ctl_o.phase_lo = phase_lo_q;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.latch = in_valid_i;
        if (in_valid_i) begin
          phase_lo_d = 1'b0;
          state_d    = in_cmd_i ? ST_S_LD : ST_A_MUL;
        end
      end
      ST_A_MUL: begin
        ctl_o.mul_sel = MUL_LO_TERM;
        state_d       = ST_A_LO;
      end
      ST_A_LO: begin
        ctl_o.ld_lo_chain = 1'b1;
        ctl_o.mul_sel     = MUL_HI_TERM;
        state_d           = ST_A_LO_WALK;
      end
      ST_A_LO_WALK: begin
        ctl_o.upd_step = 1'b1;
        if (sts_i.up_done) begin
          state_d = ST_A_HI;
        end
      end
      ST_A_HI: begin
        ctl_o.ld_hi_chain = 1'b1;
        state_d           = ST_A_HI_WALK;
      end
      ST_A_HI_WALK: begin
        ctl_o.upd_step = 1'b1;
        if (sts_i.up_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_S_LD: begin
        ctl_o.ld_pre = 1'b1;
        state_d      = ST_S_WALK;
      end
      ST_S_WALK: begin
        ctl_o.qry_step = 1'b1;
        if (sts_i.dn_done) begin
          state_d = ST_S_MUL;
        end
      end
      ST_S_MUL: begin
        ctl_o.mul_sel = MUL_PREFIX;
        state_d       = ST_S_FIN;
      end
      ST_S_FIN: begin
        if (!phase_lo_q) begin
          ctl_o.fin  = 1'b1;
          phase_lo_d = 1'b1;
          state_d    = ST_S_LD;
        end else if (!sts_i.out_full) begin
          ctl_o.fin     = 1'b1;
          ctl_o.out_set = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      phase_lo_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_lo_q <= phase_lo_d;
    end
  end

  // An accepted add beat goes straight to the multiply setup
  a_add_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_cmd_i) |=> (state_q == ST_A_MUL))
    else $error("add beat not dispatched");

  // A sum beat always starts with the prefix walk at the high end
  a_sum_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_cmd_i) |=> (state_q == ST_S_LD && !phase_lo_q))
    else $error("sum beat not dispatched to the high prefix");

  // Hold the input off while the tree is being cleared
  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_ready_o && ctl_o.clear))
    else $error("beat accepted during the clearing sweep");

endmodule

// ===== hw/rtl/range_add_range_sum_fenwick.sv =====
// Top level: range-add / range-sum Fenwick tree with stream input and output.
//
//  channel  | dir | tdata (low bit up)                                 | tuser
//  s_axis   | in  | lo_index[9:0], hi_index[19:10], add_value[51:20]   | cmd
//  m_axis   | out | range_sum[31:0]                                    | -
//
// One beat at a time. An add walks the upward chains from lo_index and hi_index + 1,
// each at most log2(TREE_SIZE) nodes long; a sum walks down the set bits of hi_index
// and of lo_index - 1, and every step shares the single tree memory port.
// After reset a clearing sweep zeroes every tree entry; no beat is taken meanwhile.
// A finished sum waits in the output register while the next beat is taken; a second
// sum holds at its last step until that register frees.
module range_add_range_sum_fenwick #(
  parameter int unsigned TREE_SIZE = fenw_pkg::TREE_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fenw_pkg::S_TDATA_W-1:0] s_axis_tdata,   // lo_index, hi_index, add_value
  input  logic                           s_axis_tuser,   // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fenw_pkg::M_TDATA_W-1:0] m_axis_tdata    // range_sum
);
  import fenw_pkg::*;

  fenw_ctl_t ctl;
  fenw_sts_t sts;

  fenw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  fenw_datapath #(
    .TREE_SIZE (TREE_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== verif/tb_range_add_range_sum_fenwick.sv =====
// Self-checking testbench for the range-add / range-sum Fenwick block.
module tb_range_add_range_sum_fenwick;
  import fenw_pkg::*;

  localparam int unsigned TREE_N    = TREE_SIZE_DEF;
  localparam int unsigned PHASE_CNT = 462;
  localparam int unsigned DIR_CNT   = 22;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned DRAIN_CYC = 64;
  localparam bit          TAB_SLOPE  = 1'b0;
  localparam bit          TAB_OFFSET = 1'b1;

  typedef enum bit {
    OP_ADD = 1'b0,
    OP_SUM = 1'b1
  } range_op_e;

  typedef struct packed {
    range_op_e        op;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [31:0]      val;
    logic             known;  // sum typed in below, else taken from the predictor
    logic [31:0]      sum;
  } dir_row_t;

  // Typed sums only where the tree is still all zero
  localparam dir_row_t DIR_ROWS [DIR_CNT] = '{
    '{OP_SUM, 10'd1,    10'd1023, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_SUM, 10'd0,    10'd0,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{OP_SUM, 10'd512,  10'd512,  32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_ADD, 10'd1,    10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1,    10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd1,    10'd1,    32'h8000_0000, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1,    10'd1,    32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd0,    10'd5,    32'h0000_0001, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd0,    10'd5,    32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1023, 10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1000, 10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd700,  10'd300,  32'h0000_3039, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd700,  10'd300,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd512,  10'd767,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd511,  10'd768,  32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd341,  10'd682,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd682,  10'd341,  32'h5555_5555, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1,    10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_ADD, 10'd1023, 10'd0,    32'h5555_5555, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd0,    10'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_SUM, 10'd1023, 10'd0,    32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: the two Fenwick tables
  bit [31:0] slope_tab  [TREE_N];
  bit [31:0] offset_tab [TREE_N];
  bit [31:0] sums_pending [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_req;
  int unsigned cmds_sent;
  int unsigned sums_checked;
  int unsigned in_stall_cyc;
  int unsigned miss_cnt;
  bit [31:0]   want_sum;

  range_add_range_sum_fenwick u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[range_add_range_sum_fenwick] ERROR");
    $finish;
  end

  function automatic void tree_point_add(bit tab, bit [31:0] pos, bit [31:0] v);
    if (pos == 32'd0) return;
    while (pos < TREE_N) begin
      if (tab == TAB_OFFSET) offset_tab[pos] += v;
      else slope_tab[pos] += v;
      pos += pos & (~pos + 32'd1);
    end
  endfunction

  function automatic bit [31:0] tree_prefix(bit [31:0] idx);
    bit [31:0] s1;
    bit [31:0] s2;
    bit [31:0] p;
    s1 = '0;
    s2 = '0;
    p  = idx;
    while (p != 32'd0) begin
      if (p < TREE_N) begin
        s1 += slope_tab[p];
        s2 += offset_tab[p];
      end
      p -= p & (~p + 32'd1);
    end
    return idx * s1 - s2;
  endfunction

  // Apply an add to the tables, or return the range sum
  function automatic bit [31:0] range_apply(range_op_e op, bit [31:0] lo, bit [31:0] hi,
                                            bit [31:0] v);
    bit [31:0] neg;
    bit [31:0] low_part;
    neg = 32'd0 - v;
    if (op == OP_ADD) begin
      tree_point_add(TAB_SLOPE, lo, v);
      tree_point_add(TAB_SLOPE, hi + 32'd1, neg);
      tree_point_add(TAB_OFFSET, lo, v * (lo - 32'd1));
      tree_point_add(TAB_OFFSET, hi + 32'd1, neg * hi);
      return 32'd0;
    end
    low_part = (lo == 32'd0) ? 32'd0 : tree_prefix(lo - 32'd1);
    return tree_prefix(hi) - low_part;
  endfunction

  task automatic send_cmd(range_op_e op, bit [IDX_W-1:0] lo, bit [IDX_W-1:0] hi,
                          bit [31:0] v, bit known, bit [31:0] typed_sum);
    bit [31:0] res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, v, hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      in_stall_cyc++;
      @(posedge clk_i);
    end
    res = range_apply(op, 32'(lo), 32'(hi), v);
    if (op == OP_SUM) sums_pending.push_back(known ? typed_sum : res);
    cmds_sent++;
  endtask

  task automatic send_random();
    range_op_e       op;
    bit [IDX_W-1:0]  lo;
    bit [IDX_W-1:0]  hi;
    int unsigned     pick;
    op   = ($urandom_range(99) < 45) ? OP_SUM : OP_ADD;
    pick = $urandom_range(99);
    lo   = IDX_W'($urandom_range(1, 1023));
    if (pick < 45) hi = IDX_W'($urandom_range(lo, (lo > 1008) ? 1023 : lo + 15));
    else if (pick < 80) hi = IDX_W'($urandom_range(lo, 1023));
    else if (pick < 90) hi = 10'd1023;
    else if (pick < 95) begin
      // random hi, possibly a reversed range
      hi = IDX_W'($urandom);
    end else begin
      lo = '0;
      hi = IDX_W'($urandom);
    end
    send_cmd(op, lo, hi, $urandom, 1'b0, 32'd0);
  endtask

  // Receiver: random stalls, plus one long hold counted here
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        n        = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sums_pending.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10) $display("unexpected range_sum beat: %h", m_axis_tdata);
      end else begin
        want_sum = sums_pending.pop_front();
        sums_checked++;
        if (m_axis_tdata !== want_sum) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("range_sum mismatch: expected %h, got %h", want_sum, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 0;
    cmds_sent     = 0;
    sums_checked  = 0;
    in_stall_cyc  = 0;
    miss_cnt      = 0;
    foreach (slope_tab[i]) begin
      slope_tab[i]  = '0;
      offset_tab[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i])
      send_cmd(DIR_ROWS[i].op, DIR_ROWS[i].lo, DIR_ROWS[i].hi, DIR_ROWS[i].val,
               DIR_ROWS[i].known, DIR_ROWS[i].sum);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 11; snk_stall_pct = 11; end
      endcase
      for (int k = 0; k < PHASE_CNT; k++) begin
        if (ph == 0 && k == 100) begin
          // Hold the output while offering sums back to back to fill the block
          hold_req = HOLD_LEN;
          for (int j = 0; j < 6; j++)
            send_cmd(OP_SUM, IDX_W'($urandom_range(1, 512)), 10'd1023, 32'd0, 1'b0, 32'd0);
        end
        send_random();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sums_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d range sums; %0d input stall cycles.",
             cmds_sent, sums_checked, in_stall_cyc);
    $display("Phases: free run, sparse input, slow output, mixed; one long output hold.");
    if (miss_cnt == 0) begin
      $display("[range_add_range_sum_fenwick] OK");
    end else begin
      $display("%0d mismatches", miss_cnt);
      $display("[range_add_range_sum_fenwick] ERROR");
    end
    $finish;
  end

endmodule

// ===== range_add_range_sum_fenwick.f =====
hw/rtl/fenw_pkg.sv
hw/rtl/fenw_ram.sv
hw/rtl/fenw_datapath.sv
hw/rtl/fenw_ctrl.sv
hw/rtl/range_add_range_sum_fenwick.sv
verif/tb_range_add_range_sum_fenwick.sv
